/* sv/ile_pkg.sv */
// Shared types and codes for the integer list engine.
package ile_pkg;

  // Default list capacity
  localparam int DEPTH_DEFAULT = 256;

  // Command codes
  localparam logic [2:0] CMD_APPEND  = 3'd0;
  localparam logic [2:0] CMD_READ    = 3'd1;
  localparam logic [2:0] CMD_FIND    = 3'd2;
  localparam logic [2:0] CMD_BSEARCH = 3'd3;
  localparam logic [2:0] CMD_REM_VAL = 3'd4;
  localparam logic [2:0] CMD_REM_IDX = 3'd5;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_IDX_ERR  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Datapath operations issued by the controller
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_APPEND,
    DP_STAT,
    DP_RD_IDX,
    DP_RD_CAP,
    DP_SCAN_START,
    DP_SCAN_STEP,
    DP_FOUND,
    DP_SHIFT_START,
    DP_SHIFT_STEP,
    DP_SHIFT_END,
    DP_BS_INIT,
    DP_BS_ISSUE,
    DP_BS_STEP,
    DP_OUT
  } dp_op_t;

  // Controller to datapath command
  typedef struct packed {
    dp_op_t     op;
    logic [1:0] stat;      // status code for DP_STAT
    logic       from_idx;  // shift start taken from the item index
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] cmd;
    logic       full;
    logic       idx_oob;
    logic       cnt_zero;
    logic       hit;
    logic       at_last;
    logic       bs_open;
  } dp_stat_t;

endpackage

/* sv/int_list_engine_core.sv */
// Integer list engine top level: a packed list of signed 32-bit entries with a count.
// Each command item gives one result item. Commands run one at a time through a single
// memory port that reads one entry per cycle; the next item is accepted when the previous
// one has finished, even while its result still waits in the output register. Find and
// remove by value scan the entries in order, remove at index shifts down the entries
// after the index, and binary search probes the middle of a shrinking window. The
// longest commands walk every stored entry.
module int_list_engine_core import ile_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] value,
  input  logic [7:0]         index,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic [1:0]         status,
  output logic signed [31:0] read_value,
  output logic [7:0]         found_position,
  output logic [8:0]         entry_count,
  output logic               is_empty
);

  ctl_cmd_t ctl;
  dp_stat_t st;

  // Sequencing
  ile_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .st        (st),
    .ctl       (ctl)
  );

  // Storage and compute
  ile_dpath #(.DEPTH(DEPTH)) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .st             (st),
    .cmd            (cmd),
    .value          (value),
    .index          (index),
    .status         (status),
    .read_value     (read_value),
    .found_position (found_position),
    .entry_count    (entry_count),
    .is_empty       (is_empty)
  );

endmodule

/* sv/ile_dpath.sv */
// Datapath of the integer list engine: entry memory, count, pointers, result registers.
module ile_dpath import ile_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  ctl_cmd_t           ctl,
  output dp_stat_t           st,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] value,
  input  logic [7:0]         index,
  output logic [1:0]         status,
  output logic signed [31:0] read_value,
  output logic [7:0]         found_position,
  output logic [8:0]         entry_count,
  output logic               is_empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > 8) ? CW : 8;

  logic signed [31:0] mem [DEPTH];

  logic [CW-1:0]      count;
  logic [2:0]         cmd_r;
  logic signed [31:0] val_r;
  logic [7:0]         idx_r;
  logic [AW-1:0]      ptr;
  logic [CW-1:0]      lo;
  logic [CW-1:0]      hi;
  logic signed [31:0] rdata;
  logic [1:0]         res_stat;
  logic signed [31:0] res_rd;
  logic [7:0]         res_pos;

  logic [AW-1:0]      raddr;
  logic               rd_en;
  logic [AW-1:0]      mid;
  logic [AW-1:0]      shift_base;

  // Probe point and shift start
  assign mid        = AW'(lo + ((hi - lo) >> 1));
  assign shift_base = ctl.from_idx ? AW'(idx_r) : ptr;

  // Status toward the controller
  assign st.cmd      = cmd_r;
  assign st.full     = (count >= CW'(DEPTH));
  assign st.idx_oob  = (CMPW'(idx_r) >= CMPW'(count));
  assign st.cnt_zero = (count == '0);
  assign st.hit      = (rdata == val_r);
  assign st.at_last  = (CW'(ptr) == count - CW'(1));
  assign st.bs_open  = (lo < hi);

  // Select the read address
  always_comb begin
    raddr = ptr;
    rd_en = 1'b0;
    case (ctl.op)
      DP_RD_IDX: begin
        raddr = AW'(idx_r);
        rd_en = 1'b1;
      end
      DP_SCAN_START: begin
        raddr = '0;
        rd_en = 1'b1;
      end
      DP_SCAN_STEP: begin
        raddr = ptr + AW'(1);
        rd_en = 1'b1;
      end
      DP_SHIFT_START: begin
        raddr = shift_base + AW'(1);
        rd_en = 1'b1;
      end
      DP_SHIFT_STEP: begin
        raddr = ptr + AW'(2);
        rd_en = 1'b1;
      end
      DP_BS_ISSUE: begin
        raddr = mid;
        rd_en = 1'b1;
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  // Entry memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (ctl.op == DP_APPEND) begin
      mem[AW'(count)] <= val_r;
    end else if (ctl.op == DP_SHIFT_STEP) begin
      mem[ptr] <= rdata;
    end
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.op == DP_APPEND) begin
      count <= count + CW'(1);
    end else if (ctl.op == DP_SHIFT_END) begin
      count <= count - CW'(1);
    end
  end

  // Operands, pointers and results
  always_ff @(posedge clk) begin
    case (ctl.op)
      DP_LOAD: begin
        cmd_r    <= cmd;
        val_r    <= value;
        idx_r    <= index;
        res_stat <= ST_OK;
        res_rd   <= '0;
        res_pos  <= '0;
      end
      DP_STAT:        res_stat <= ctl.stat;
      DP_RD_CAP:      res_rd   <= rdata;
      DP_SCAN_START:  ptr      <= '0;
      DP_SCAN_STEP:   ptr      <= ptr + AW'(1);
      DP_FOUND:       res_pos  <= 8'(ptr);
      DP_SHIFT_START: ptr      <= shift_base;
      DP_SHIFT_STEP:  ptr      <= ptr + AW'(1);
      DP_BS_INIT: begin
        lo <= '0;
        hi <= count;
      end
      DP_BS_ISSUE:    ptr      <= mid;
      DP_BS_STEP: begin
        if (val_r > rdata) begin
          lo <= CW'(ptr) + CW'(1);
        end else begin
          hi <= CW'(ptr);
        end
      end
      DP_OUT: begin
        status         <= res_stat;
        read_value     <= res_rd;
        found_position <= res_pos;
        entry_count    <= 9'(count);
        is_empty       <= (count == '0);
      end
      default: begin
      end
    endcase
  end

endmodule

/* sv/ile_ctrl.sv */
// Controller of the integer list engine: command sequencing and handshakes.
module ile_ctrl import ile_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  input  dp_stat_t st,
  output ctl_cmd_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_READ_WAIT,
    S_SCAN,
    S_SHIFT,
    S_BS_CHK,
    S_BS_CMP,
    S_FIN
  } state_t;

  state_t state;
  state_t state_next;

  assign req_ready = (state == S_IDLE);

  // Next state and datapath command
  always_comb begin
    state_next   = state;
    ctl.op       = DP_NOP;
    ctl.stat     = ST_OK;
    ctl.from_idx = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.op     = DP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_next = S_FIN;
        unique case (st.cmd)
          CMD_APPEND: begin
            if (st.full) begin
              ctl.op   = DP_STAT;
              ctl.stat = ST_FULL;
            end else begin
              ctl.op = DP_APPEND;
            end
          end
          CMD_READ: begin
            if (st.idx_oob) begin
              ctl.op   = DP_STAT;
              ctl.stat = ST_IDX_ERR;
            end else begin
              ctl.op     = DP_RD_IDX;
              state_next = S_READ_WAIT;
            end
          end
          CMD_FIND, CMD_REM_VAL: begin
            if (st.cnt_zero) begin
              ctl.op   = DP_STAT;
              ctl.stat = ST_NOTFOUND;
            end else begin
              ctl.op     = DP_SCAN_START;
              state_next = S_SCAN;
            end
          end
          CMD_BSEARCH: begin
            ctl.op     = DP_BS_INIT;
            state_next = S_BS_CHK;
          end
          CMD_REM_IDX: begin
            if (st.idx_oob) begin
              ctl.op   = DP_STAT;
              ctl.stat = ST_IDX_ERR;
            end else begin
              ctl.op       = DP_SHIFT_START;
              ctl.from_idx = 1'b1;
              state_next   = S_SHIFT;
            end
          end
          default: begin
            ctl.op = DP_NOP;
          end
        endcase
      end
      S_READ_WAIT: begin
        ctl.op     = DP_RD_CAP;
        state_next = S_FIN;
      end
      S_SCAN: begin
        // Compare the entry read last cycle, fetch the next one
        if (st.hit) begin
          if (st.cmd == CMD_FIND) begin
            ctl.op     = DP_FOUND;
            state_next = S_FIN;
          end else begin
            ctl.op     = DP_SHIFT_START;
            state_next = S_SHIFT;
          end
        end else if (st.at_last) begin
          ctl.op     = DP_STAT;
          ctl.stat   = ST_NOTFOUND;
          state_next = S_FIN;
        end else begin
          ctl.op = DP_SCAN_STEP;
        end
      end
      S_SHIFT: begin
        if (st.at_last) begin
          ctl.op     = DP_SHIFT_END;
          state_next = S_FIN;
        end else begin
          ctl.op = DP_SHIFT_STEP;
        end
      end
      S_BS_CHK: begin
        if (st.bs_open) begin
          ctl.op     = DP_BS_ISSUE;
          state_next = S_BS_CMP;
        end else begin
          ctl.op     = DP_STAT;
          ctl.stat   = ST_NOTFOUND;
          state_next = S_FIN;
        end
      end
      S_BS_CMP: begin
        if (st.hit) begin
          ctl.op     = DP_FOUND;
          state_next = S_FIN;
        end else begin
          ctl.op     = DP_BS_STEP;
          state_next = S_BS_CHK;
        end
      end
      S_FIN: begin
        // Hold until the output register is free
        if (!rsp_valid || rsp_ready) begin
          ctl.op     = DP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.op == DP_OUT) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

/* sv/ile_checker.sv */
// Port-level checks for the integer list engine, bound to the top level.
module ile_checker import ile_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [1:0]         status,
  input logic signed [31:0] read_value,
  input logic [7:0]         found_position,
  input logic [8:0]         entry_count,
  input logic               is_empty
);

  // Come out of reset idle and ready
  a_reset_idle: assert property (@(posedge clk) rst |=> (!rsp_valid && req_ready))
    else $error("not idle after reset");

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(status) && $stable(read_value)
      && $stable(found_position) && $stable(entry_count)))
    else $error("stalled result changed");

  // Empty flag tracks the count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (is_empty == (entry_count == 9'd0)))
    else $error("empty flag disagrees with count");

  // Failed commands carry zero data fields
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && status != ST_OK) |-> (read_value == 32'sd0 && found_position == 8'd0))
    else $error("nonzero data on failed command");

  // A new result only appears while no item is being taken
  a_rsp_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> !$past(req_ready))
    else $error("result raised while idle");

endmodule

bind int_list_engine_core ile_checker u_ile_checker (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req_valid),
  .req_ready      (req_ready),
  .rsp_valid      (rsp_valid),
  .rsp_ready      (rsp_ready),
  .status         (status),
  .read_value     (read_value),
  .found_position (found_position),
  .entry_count    (entry_count),
  .is_empty       (is_empty)
);

/* bench/testbench.sv */
// Self-checking testbench for the integer list engine core.
module testbench;
  import ile_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEFAULT;
  // Command codes that the engine ignores
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;
  localparam int ITEM_TARGET = 1150;
  localparam int LONG_HOLD_CYCLES = 400;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_NEG1 = 32'shFFFF_FFFF;

  typedef struct packed {
    logic [1:0]         st;
    logic signed [31:0] rd;
    logic [7:0]         pos;
    logic [8:0]         cnt;
    logic               emp;
  } list_rsp_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] val;
    logic [7:0]         ix;
    logic               typed;
    list_rsp_t          res;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               req_valid;
  logic               req_ready;
  logic [2:0]         cmd;
  logic signed [31:0] value;
  logic [7:0]         index;
  logic               rsp_valid;
  logic               rsp_ready;
  logic [1:0]         status;
  logic signed [31:0] read_value;
  logic [7:0]         found_position;
  logic [8:0]         entry_count;
  logic               is_empty;

  // Shadow copy of the list and the results still owed by the engine
  logic signed [31:0] list_mem [LIST_DEPTH];
  int                 list_cnt;
  list_rsp_t          pending_rsp [$];
  dir_row_t           dir_rows [$];
  int                 err_cnt;
  int                 n_sent;
  bit                 idle_on;
  bit                 long_hold;

  int_list_engine_core #(.DEPTH(LIST_DEPTH)) u_top (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .cmd            (cmd),
    .value          (value),
    .index          (index),
    .rsp_valid      (rsp_valid),
    .rsp_ready      (rsp_ready),
    .status         (status),
    .read_value     (read_value),
    .found_position (found_position),
    .entry_count    (entry_count),
    .is_empty       (is_empty)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Remove one entry and close the gap
  function automatic void list_drop(input int at);
    int j;
    for (j = at; j + 1 < list_cnt; j++) list_mem[j] = list_mem[j + 1];
    list_cnt--;
  endfunction

  // Apply one command to the shadow list and return the result it gives
  function automatic list_rsp_t list_exec(input logic [2:0] op, input logic signed [31:0] val,
                                          input logic [7:0] ix);
    list_rsp_t r;
    int        i, hit_at, lo, hi, mid;
    r = '0;
    hit_at = -1;
    case (op)
      CMD_APPEND: begin
        if (list_cnt >= LIST_DEPTH) begin
          r.st = ST_FULL;
        end else begin
          list_mem[list_cnt] = val;
          list_cnt++;
        end
      end
      CMD_READ: begin
        if (ix >= list_cnt) r.st = ST_IDX_ERR;
        else r.rd = list_mem[ix];
      end
      CMD_FIND, CMD_REM_VAL: begin
        for (i = 0; i < list_cnt && hit_at < 0; i++) begin
          if (list_mem[i] == val) hit_at = i;
        end
        if (hit_at < 0) r.st = ST_NOTFOUND;
        else if (op == CMD_FIND) r.pos = 8'(hit_at);
        else list_drop(hit_at);
      end
      CMD_BSEARCH: begin
        // probe with low/high/mid until a hit or the window closes
        r.st = ST_NOTFOUND;
        lo = 0;
        hi = list_cnt;
        while (lo < hi && r.st != ST_OK) begin
          mid = lo + (hi - lo) / 2;
          if (list_mem[mid] == val) begin
            r.st = ST_OK;
            r.pos = 8'(mid);
          end else if (val > list_mem[mid]) begin
            lo = mid + 1;
          end else begin
            hi = mid;
          end
        end
      end
      CMD_REM_IDX: begin
        if (ix >= list_cnt) r.st = ST_IDX_ERR;
        else list_drop(ix);
      end
      default: ;
    endcase
    r.cnt = 9'(list_cnt);
    r.emp = (list_cnt == 0);
    return r;
  endfunction

  function automatic logic signed [31:0] pool_val(input int k);
    case (k)
      0: return VAL_MIN;
      1: return VAL_NEG1;
      2: return 32'sd0;
      3: return 32'sd1;
      4: return VAL_MAX;
      5: return 32'sd7;
      6: return -32'sd7;
      default: return 32'sd100;
    endcase
  endfunction

  function automatic void tbl_row(input logic [2:0] op, input logic signed [31:0] val,
                                  input logic [7:0] ix, input bit typed, input logic [1:0] st,
                                  input logic signed [31:0] rd, input logic [7:0] pos,
                                  input logic [8:0] cnt);
    dir_row_t dr;
    dr.op = op;
    dr.val = val;
    dr.ix = ix;
    dr.typed = typed;
    dr.res.st = st;
    dr.res.rd = rd;
    dr.res.pos = pos;
    dr.res.cnt = cnt;
    dr.res.emp = (cnt == 0);
    dir_rows.push_back(dr);
  endfunction

  // Offer one item, hold it until accepted, then record what it must give
  task automatic issue_item(input logic [2:0] op, input logic signed [31:0] val,
                            input logic [7:0] ix, input bit typed, input list_rsp_t typed_res);
    list_rsp_t r;
    int        gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    cmd <= op;
    value <= val;
    index <= ix;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    r = list_exec(op, val, ix);
    pending_rsp.push_back(typed ? typed_res : r);
    n_sent++;
  endtask

  task automatic issue_cmd(input logic [2:0] op, input logic signed [31:0] val,
                           input logic [7:0] ix);
    issue_item(op, val, ix, 1'b0, '0);
  endtask

  // Random command with values taken from the list, from a small pool or at random
  task automatic issue_random_cmd();
    logic [2:0]         op;
    logic signed [31:0] val;
    logic [7:0]         ix;
    int                 pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) op = CMD_APPEND;
    else if (pick < 42) op = CMD_READ;
    else if (pick < 54) op = CMD_FIND;
    else if (pick < 64) op = CMD_BSEARCH;
    else if (pick < 76) op = CMD_REM_VAL;
    else if (pick < 90) op = CMD_REM_IDX;
    else if (pick < 95) op = CMD_RSVD6;
    else op = CMD_RSVD7;
    case ($urandom_range(0, 3))
      0: val = $urandom;
      1: val = (list_cnt > 0) ? list_mem[$urandom_range(0, list_cnt - 1)]
                              : pool_val($urandom_range(0, 7));
      default: val = pool_val($urandom_range(0, 7));
    endcase
    if (list_cnt > 0 && $urandom_range(0, 4) != 0) ix = 8'($urandom_range(0, list_cnt - 1));
    else ix = 8'($urandom_range(0, 255));
    issue_cmd(op, val, ix);
  endtask

  // Stop offering and wait for every owed result
  task automatic drain();
    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string nm, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %0h, got %0h", $time, nm, e, a);
      err_cnt++;
    end
  endtask

  // Result side: check accepted items and drive ready with stall bursts
  initial begin : rsp_side
    int        stall_left;
    int        hold_left;
    list_rsp_t exp_r;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t: result with nothing expected, status %0d count %0d",
                   $time, status, entry_count);
          err_cnt++;
        end else begin
          exp_r = pending_rsp.pop_front();
          check_field("status", exp_r.st, status);
          check_field("read_value", exp_r.rd, read_value);
          check_field("found_position", exp_r.pos, found_position);
          check_field("entry_count", exp_r.cnt, entry_count);
          check_field("is_empty", exp_r.emp, is_empty);
        end
      end
      if (long_hold) begin
        long_hold = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(1, 17) - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Stimulus: directed table, then shaped random phases
  initial begin : stim
    dir_row_t           dr;
    logic signed [31:0] val;
    int                 k, n, rnd, pick;
    rst = 1'b1;
    req_valid = 1'b0;
    cmd = CMD_APPEND;
    value = '0;
    index = '0;
    rsp_ready = 1'b0;
    err_cnt = 0;
    n_sent = 0;
    list_cnt = 0;
    idle_on = 1'b1;
    long_hold = 1'b0;

    //      op           value        ix     typed  status       read     pos   count
    tbl_row(CMD_READ,    32'sd0,      8'd0,   1, ST_IDX_ERR,  32'sd0,  8'd0, 9'd0);
    tbl_row(CMD_REM_IDX, 32'sd0,      8'd0,   1, ST_IDX_ERR,  32'sd0,  8'd0, 9'd0);
    tbl_row(CMD_FIND,    32'sd5,      8'd0,   1, ST_NOTFOUND, 32'sd0,  8'd0, 9'd0);
    tbl_row(CMD_BSEARCH, 32'sd5,      8'd0,   1, ST_NOTFOUND, 32'sd0,  8'd0, 9'd0);
    tbl_row(CMD_REM_VAL, 32'sd5,      8'd0,   1, ST_NOTFOUND, 32'sd0,  8'd0, 9'd0);
    tbl_row(CMD_RSVD6,   VAL_NEG1,    8'hFF,  1, ST_OK,       32'sd0,  8'd0, 9'd0);
    tbl_row(CMD_RSVD7,   VAL_MIN,     8'd0,   1, ST_OK,       32'sd0,  8'd0, 9'd0);
    tbl_row(CMD_APPEND,  VAL_MIN,     8'd0,   1, ST_OK,       32'sd0,  8'd0, 9'd1);
    tbl_row(CMD_APPEND,  VAL_NEG1,    8'hFF,  1, ST_OK,       32'sd0,  8'd0, 9'd2);
    tbl_row(CMD_APPEND,  32'sd0,      8'd0,   1, ST_OK,       32'sd0,  8'd0, 9'd3);
    tbl_row(CMD_APPEND,  VAL_MAX,     8'd0,   1, ST_OK,       32'sd0,  8'd0, 9'd4);
    tbl_row(CMD_APPEND,  VAL_MAX,     8'd0,   1, ST_OK,       32'sd0,  8'd0, 9'd5);
    tbl_row(CMD_READ,    32'sd0,      8'd0,   1, ST_OK,       VAL_MIN, 8'd0, 9'd5);
    tbl_row(CMD_READ,    32'sd0,      8'd3,   1, ST_OK,       VAL_MAX, 8'd0, 9'd5);
    tbl_row(CMD_READ,    32'sd0,      8'd5,   1, ST_IDX_ERR,  32'sd0,  8'd0, 9'd5);
    tbl_row(CMD_READ,    32'sd0,      8'd255, 1, ST_IDX_ERR,  32'sd0,  8'd0, 9'd5);
    tbl_row(CMD_FIND,    VAL_MAX,     8'd0,   1, ST_OK,       32'sd0,  8'd3, 9'd5);
    tbl_row(CMD_BSEARCH, VAL_MIN,     8'd0,   0, ST_OK,       32'sd0,  8'd0, 9'd0);
    tbl_row(CMD_BSEARCH, VAL_MAX,     8'd0,   0, ST_OK,       32'sd0,  8'd0, 9'd0);
    tbl_row(CMD_BSEARCH, 32'sd1,      8'd0,   0, ST_OK,       32'sd0,  8'd0, 9'd0);
    tbl_row(CMD_REM_VAL, VAL_MAX,     8'd0,   0, ST_OK,       32'sd0,  8'd0, 9'd0);
    tbl_row(CMD_REM_IDX, 32'sd0,      8'd0,   0, ST_OK,       32'sd0,  8'd0, 9'd0);
    tbl_row(CMD_REM_IDX, 32'sd0,      8'd2,   0, ST_OK,       32'sd0,  8'd0, 9'd0);
    tbl_row(CMD_READ,    32'sd0,      8'd1,   0, ST_OK,       32'sd0,  8'd0, 9'd0);
    tbl_row(CMD_FIND,    VAL_NEG1,    8'd0,   0, ST_OK,       32'sd0,  8'd0, 9'd0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < dir_rows.size(); k++) begin
      dr = dir_rows[k];
      issue_item(dr.op, dr.val, dr.ix, dr.typed, dr.res);
    end

    // Mixed traffic; the result side holds off for a long stretch at the start
    long_hold = 1'b1;
    repeat (300) issue_random_cmd();
    drain();

    // Sorted lists with binary search, some noise mixed in
    for (rnd = 0; rnd < 4; rnd++) begin
      while (list_cnt > 0) issue_cmd(CMD_REM_IDX, $urandom, 8'($urandom_range(0, list_cnt - 1)));
      k = $urandom_range(1, 40);
      val = (rnd == 0) ? VAL_MIN : ($signed($urandom) >>> 2);
      for (n = 0; n < k; n++) begin
        issue_cmd(CMD_APPEND, val, 8'($urandom));
        val = val + ((rnd == 1) ? $urandom_range(0, 2) : $urandom_range(1, 1 << 24));
      end
      if (rnd == 0) issue_cmd(CMD_APPEND, VAL_MAX, 8'd0);
      repeat (25) begin
        pick = $urandom_range(0, 19);
        if (list_cnt == 0) val = $urandom;
        else if (pick < 12) val = list_mem[$urandom_range(0, list_cnt - 1)];
        else if (pick < 16) val = list_mem[$urandom_range(0, list_cnt - 1)] + 1;
        else val = $urandom;
        if (pick < 2) issue_random_cmd();
        else if (pick < 4) issue_cmd(CMD_FIND, val, 8'($urandom));
        else if (pick == 4) issue_cmd(CMD_READ, val, 8'($urandom_range(0, 255)));
        else issue_cmd(CMD_BSEARCH, val, 8'($urandom));
      end
    end

    // Fill to capacity, push on a full list, then work and shrink it
    while (list_cnt < LIST_DEPTH) begin
      if ($urandom_range(0, 3) == 0) val = $urandom;
      else val = pool_val($urandom_range(0, 7));
      issue_cmd(CMD_APPEND, val, 8'($urandom));
    end
    repeat (3) issue_cmd(CMD_APPEND, $urandom, 8'd0);
    issue_cmd(CMD_READ, 32'sd0, 8'd255);
    issue_cmd(CMD_FIND, list_mem[LIST_DEPTH - 1], 8'd0);
    issue_cmd(CMD_BSEARCH, list_mem[LIST_DEPTH / 2], 8'd0);
    issue_cmd(CMD_REM_IDX, 32'sd0, 8'd255);
    issue_cmd(CMD_APPEND, VAL_MAX, 8'd0);
    repeat (60) issue_random_cmd();
    while (list_cnt > 40) begin
      if ($urandom_range(0, 3) == 0)
        issue_cmd(CMD_REM_VAL, list_mem[$urandom_range(0, list_cnt - 1)], 8'($urandom));
      else
        issue_cmd(CMD_REM_IDX, $urandom, 8'($urandom_range(0, list_cnt - 1)));
    end
    drain();

    // Final stretch at full rate
    idle_on = 1'b0;
    n = 0;
    while (n_sent < ITEM_TARGET || n < 80) begin
      issue_random_cmd();
      n++;
    end
    drain();
    repeat (300) @(posedge clk);

    if (err_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Hang guard
  initial begin
    #8000000;
    $display("FAILURE");
    $finish;
  end

endmodule
